[src/hbr_pkg.sv]
// hbr_pkg: shared types, constants and state encodings for the histogram bar-row block
// no dependencies; imported by every module under src

package hbr_pkg;

    localparam int DEF_NUM_BUCKETS = 64;
    localparam int DEF_ROWS        = 10;
    localparam int DEF_COUNT_BITS  = 24;

    localparam int VAL_W       = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int ROW_IDX_W   = 4;
    localparam int ROW_BITS_W  = 64;
    localparam int MAX_BKT_W   = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_SEL   = 2'd2;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;
    localparam logic [1:0] COMP_W = 2'd3;

    typedef struct packed {
        logic [MAX_BKT_W-1:0] bucket;
        logic                 last_sample;
    } t_qent;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_CHK,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_UPD,
        B_PK_RD,
        B_PK_CMP,
        B_THR,
        B_BT_RD,
        B_BT_CMP,
        B_EMIT
    } t_bstate;

endpackage

[src/hbr_front.sv]
// hbr_front: accepts samples, picks the component and computes its bucket
// depends on hbr_pkg; feeds hbr_fifo

module hbr_front #(
    parameter int NUM_BUCKETS = hbr_pkg::DEF_NUM_BUCKETS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [hbr_pkg::VAL_W-1:0]   i_comp_x,
    input  logic signed [hbr_pkg::VAL_W-1:0]   i_comp_y,
    input  logic signed [hbr_pkg::VAL_W-1:0]   i_comp_z,
    input  logic signed [hbr_pkg::VAL_W-1:0]   i_comp_w,
    input  logic                               i_final_sample,
    input  logic signed [hbr_pkg::VAL_W-1:0]   i_range_low,
    input  logic signed [hbr_pkg::VAL_W-1:0]   i_range_high,
    input  logic [1:0]                         i_comp_sel,
    output logic                               o_push,
    output hbr_pkg::t_qent                     o_push_data,
    input  logic                               i_full
);
    import hbr_pkg::*;

    localparam int BKT_W  = $clog2(NUM_BUCKETS);
    localparam int DIFF_W = VAL_W + 1;
    localparam int NUM_W  = DIFF_W + BKT_W;
    localparam int UN_W   = NUM_W - 1;
    localparam int CNT_W  = $clog2(BKT_W + 1);
    localparam logic signed [NUM_W-1:0] BKT_SCALE = NUM_W'(NUM_BUCKETS - 1);
    localparam logic [BKT_W-1:0]        BKT_TOP   = BKT_W'(NUM_BUCKETS - 1);

    t_fstate                  r_state, n_state;
    logic signed [DIFF_W-1:0] r_diff, r_span;
    logic signed [NUM_W-1:0]  r_num;
    logic [UN_W-1:0]          r_rem, r_dvs;
    logic [BKT_W-1:0]         r_q, r_bkt;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_last;

    logic signed [VAL_W-1:0]  w_pick;
    logic                     w_accept, w_span_bad, w_num_neg, w_over, w_sub;
    logic [UN_W-1:0]          w_num_mag, w_span_top;
    logic [BKT_W-1:0]         w_q_next;

    always_comb begin
        case (i_comp_sel)
            COMP_X:  w_pick = i_comp_x;
            COMP_Y:  w_pick = i_comp_y;
            COMP_Z:  w_pick = i_comp_z;
            COMP_W:  w_pick = i_comp_w;
            default: w_pick = i_comp_x;
        endcase
    end

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_span_bad = r_span[DIFF_W-1] || (r_span == '0);
    assign w_num_neg  = r_num[NUM_W-1];
    assign w_num_mag  = r_num[UN_W-1:0];
    assign w_span_top = UN_W'(r_span[VAL_W-1:0]) << BKT_W;
    assign w_over     = w_num_mag >= w_span_top;
    assign w_sub      = r_rem >= r_dvs;
    assign w_q_next   = BKT_W'({r_q, w_sub});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (w_accept) n_state = F_MUL;
            end
            F_MUL: begin
                n_state = w_span_bad ? F_PUSH : F_CHK;
            end
            F_CHK: begin
                n_state = (w_num_neg || w_over) ? F_PUSH : F_DIV;
            end
            F_DIV: begin
                if (r_cnt == CNT_W'(1)) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall              = (r_state != F_IDLE);
        o_push                  = (r_state == F_PUSH) && !i_full;
        o_push_data.bucket      = MAX_BKT_W'(r_bkt);
        o_push_data.last_sample = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    r_diff <= DIFF_W'(w_pick) - DIFF_W'(i_range_low);
                    r_span <= DIFF_W'(i_range_high) - DIFF_W'(i_range_low);
                    r_last <= i_final_sample;
                end
            end
            F_MUL: begin
                r_num <= NUM_W'(r_diff) * BKT_SCALE;
                if (w_span_bad) r_bkt <= '0;
            end
            F_CHK: begin
                if (w_num_neg) begin
                    r_bkt <= '0;
                end else if (w_over) begin
                    r_bkt <= BKT_TOP;
                end else begin
                    r_rem <= w_num_mag;
                    r_dvs <= UN_W'(r_span[VAL_W-1:0]) << (BKT_W - 1);
                    r_q   <= '0;
                    r_cnt <= CNT_W'(BKT_W);
                end
            end
            F_DIV: begin
                if (w_sub) r_rem <= r_rem - r_dvs;
                r_dvs <= r_dvs >> 1;
                r_q   <= w_q_next;
                r_cnt <= r_cnt - CNT_W'(1);
                r_bkt <= (w_q_next > BKT_TOP) ? BKT_TOP : w_q_next;
            end
            default: ;
        endcase
    end

endmodule

[src/hbr_fifo.sv]
// hbr_fifo: short queue of bucket transactions between front and back
// depends on hbr_pkg

module hbr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hbr_pkg::t_qent i_push_data,
    output logic           o_full,
    input  logic           i_pop,
    output hbr_pkg::t_qent o_head,
    output logic           o_empty
);
    import hbr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_qent            r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slots[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + PTR_W'(1);
            if (i_pop)  r_rptr <= r_rptr + PTR_W'(1);
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slots[r_wptr] <= i_push_data;
    end

endmodule

[src/hbr_back.sv]
// hbr_back: bucket count memory, peak search, row thresholds and row emission
// depends on hbr_pkg; drains hbr_fifo

module hbr_back #(
    parameter int NUM_BUCKETS = hbr_pkg::DEF_NUM_BUCKETS,
    parameter int ROWS        = hbr_pkg::DEF_ROWS,
    parameter int COUNT_BITS  = hbr_pkg::DEF_COUNT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hbr_pkg::t_qent                     i_head,
    input  logic                               i_empty,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [hbr_pkg::ROW_IDX_W-1:0]      o_row_index,
    output logic [hbr_pkg::ROW_BITS_W-1:0]     o_row_bits,
    output logic                               o_row_last
);
    import hbr_pkg::*;

    localparam int BKT_W  = $clog2(NUM_BUCKETS);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PROD_W = COUNT_BITS + $clog2(ROWS + 1);
    localparam logic [BKT_W-1:0]  BKT_LAST = BKT_W'(NUM_BUCKETS - 1);
    localparam logic [ROW_W-1:0]  ROW_TOP  = ROW_W'(ROWS - 1);
    localparam logic [PROD_W-1:0] ROWS_P   = PROD_W'(ROWS);

    t_bstate               r_state, n_state;

    logic [COUNT_BITS-1:0] r_counts [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_vld;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_rd_vld;

    logic [BKT_W-1:0]      r_bkt, r_idx;
    logic                  r_last;
    logic [COUNT_BITS-1:0] r_peak;
    logic [PROD_W-1:0]     r_tq;
    logic [ROW_W-1:0]      r_row;
    logic [PROD_W-1:0]     r_thr     [ROWS];
    logic [NUM_BUCKETS-1:0] r_rowbits [ROWS];

    logic [COUNT_BITS-1:0] w_count, w_inc, w_peak_next;
    logic [PROD_W-1:0]     w_scaled;
    logic [BKT_W-1:0]      w_raddr;
    logic                  w_we, w_out_take;

    assign w_count     = r_rd_vld ? r_rd_data : '0;
    assign w_inc       = (&w_count) ? w_count : w_count + COUNT_BITS'(1);
    assign w_peak_next = (w_count > r_peak) ? w_count : r_peak;
    assign w_scaled    = PROD_W'(w_count) * ROWS_P;
    assign w_raddr     = (r_state == B_IDLE) ? i_head.bucket[BKT_W-1:0] : r_idx;
    assign w_we        = (r_state == B_UPD);
    assign w_out_take  = o_out_valid && !i_out_stall;

    // count memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) r_counts[r_bkt] <= w_inc;
        r_rd_data <= r_counts[w_raddr];
        r_rd_vld  <= r_vld[w_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) n_state = B_UPD;
            end
            B_UPD: begin
                n_state = r_last ? B_PK_RD : B_IDLE;
            end
            B_PK_RD: begin
                n_state = B_PK_CMP;
            end
            B_PK_CMP: begin
                n_state = (r_idx == BKT_LAST) ? B_THR : B_PK_RD;
            end
            B_THR: begin
                if (r_row == ROW_TOP) n_state = B_BT_RD;
            end
            B_BT_RD: begin
                n_state = B_BT_CMP;
            end
            B_BT_CMP: begin
                n_state = (r_idx == BKT_LAST) ? B_EMIT : B_BT_RD;
            end
            B_EMIT: begin
                if (w_out_take && (r_row == '0)) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop       = (r_state == B_IDLE) && !i_empty;
        o_out_valid = (r_state == B_EMIT);
        o_row_index = ROW_IDX_W'(r_row);
        o_row_bits  = ROW_BITS_W'(r_rowbits[r_row]);
        o_row_last  = (r_row == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (w_we) begin
                r_vld[r_bkt] <= 1'b1;
            end else if ((r_state == B_EMIT) && w_out_take && (r_row == '0)) begin
                r_vld <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    r_bkt  <= i_head.bucket[BKT_W-1:0];
                    r_last <= i_head.last_sample;
                end
            end
            B_UPD: begin
                r_idx  <= '0;
                r_peak <= '0;
            end
            B_PK_CMP: begin
                r_peak <= w_peak_next;
                if (r_idx == BKT_LAST) begin
                    r_row <= '0;
                    r_tq  <= '0;
                end else begin
                    r_idx <= r_idx + BKT_W'(1);
                end
            end
            // row r keeps r * peak; a count is above the row when count * rows > r * peak
            B_THR: begin
                r_thr[r_row] <= r_tq;
                r_tq  <= r_tq + PROD_W'(r_peak);
                r_idx <= '0;
                if (r_row != ROW_TOP) r_row <= r_row + ROW_W'(1);
            end
            B_BT_CMP: begin
                for (int r = 0; r < ROWS; r++) begin
                    r_rowbits[r][r_idx] <= (w_scaled > r_thr[r]);
                end
                if (r_idx == BKT_LAST) begin
                    r_row <= ROW_TOP;
                end else begin
                    r_idx <= r_idx + BKT_W'(1);
                end
            end
            B_EMIT: begin
                if (w_out_take && (r_row != '0)) r_row <= r_row - ROW_W'(1);
            end
            default: ;
        endcase
    end

endmodule

[src/histogram_bar_rows.sv]
// histogram_bar_rows: top level, configuration registers and block assembly
// depends on hbr_pkg, hbr_front, hbr_fifo and hbr_back
//
// usage
//   configuration: write range_low, range_high and component_select through
//   i_cfg_wen / i_cfg_index / i_cfg_wdata while the block is idle
//   input channel: one sample per transaction (i_in_valid, o_in_stall)
//   output channel: one bar row per transaction (o_out_valid, i_out_stall),
//   rows come from the top row down, o_row_last marks row 0
//   the front takes a new sample only after it has pushed the last one; it
//   runs multiply, check, the one-bit-per-cycle bucket divider and push,
//   skips the divider when the value clamps and goes from multiply to push
//   when the range is empty; the back reads and then writes one count per
//   queue entry, behind a 4-entry queue; after the final sample of a frame:
//   peak search over all buckets, one threshold per row, row bit build,
//   then one row per cycle while not stalled
//   a stalled row holds; samples keep queueing and then stall the input
//   reset: registers to their defaults, counts read as zero at once
//   through per-bucket valid flags; no clearing pass

module histogram_bar_rows #(
    parameter int NUM_BUCKETS = hbr_pkg::DEF_NUM_BUCKETS,
    parameter int ROWS        = hbr_pkg::DEF_ROWS,
    parameter int COUNT_BITS  = hbr_pkg::DEF_COUNT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wen,
    input  logic [hbr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hbr_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [hbr_pkg::VAL_W-1:0]   i_comp_x,
    input  logic signed [hbr_pkg::VAL_W-1:0]   i_comp_y,
    input  logic signed [hbr_pkg::VAL_W-1:0]   i_comp_z,
    input  logic signed [hbr_pkg::VAL_W-1:0]   i_comp_w,
    input  logic                               i_final_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [hbr_pkg::ROW_IDX_W-1:0]      o_row_index,
    output logic [hbr_pkg::ROW_BITS_W-1:0]     o_row_bits,
    output logic                               o_row_last
);
    import hbr_pkg::*;

    logic signed [VAL_W-1:0] r_range_low, r_range_high;
    logic [1:0]              r_comp_sel;

    logic  w_push, w_full, w_pop, w_empty;
    t_qent w_push_data, w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= VAL_W'(65536);
            r_comp_sel   <= COMP_X;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                CFG_RANGE_LOW:  r_range_low  <= i_cfg_wdata;
                CFG_RANGE_HIGH: r_range_high <= i_cfg_wdata;
                CFG_COMP_SEL:   r_comp_sel   <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    hbr_front #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_comp_x       (i_comp_x),
        .i_comp_y       (i_comp_y),
        .i_comp_z       (i_comp_z),
        .i_comp_w       (i_comp_w),
        .i_final_sample (i_final_sample),
        .i_range_low    (r_range_low),
        .i_range_high   (r_range_high),
        .i_comp_sel     (r_comp_sel),
        .o_push         (w_push),
        .o_push_data    (w_push_data),
        .i_full         (w_full)
    );

    hbr_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_empty     (w_empty)
    );

    hbr_back #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .ROWS        (ROWS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_row_index (o_row_index),
        .o_row_bits  (o_row_bits),
        .o_row_last  (o_row_last)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue pop while empty");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("front took a second transaction back to back");

    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_row_last) |=> !o_out_valid)
        else $error("row output continued past the last row");

endmodule

[bench/histogram_bar_rows_tb.sv]
// histogram_bar_rows_tb: self-checking bench for the histogram bar-row block
// depends on hbr_pkg and histogram_bar_rows; a scoreboard class predicts every bar row
// directed frames cover range extremes and degenerate ranges, then random frames follow
`timescale 1ns / 100ps

module histogram_bar_rows_tb;
    import hbr_pkg::*;

    localparam int NUM_BUCKETS   = DEF_NUM_BUCKETS;
    localparam int ROWS          = DEF_ROWS;
    localparam int COUNT_BITS    = DEF_COUNT_BITS;
    localparam int RANDOM_ITEMS  = 140;
    localparam int STEADY_ITEMS  = 30;
    localparam int SETTLE_CYCLES = 400;
    localparam int TIMEOUT_NS    = 12 * 2000000;

    typedef struct {
        logic [ROW_IDX_W-1:0]  index;
        logic [ROW_BITS_W-1:0] bits;
        logic                  last;
    } t_bar_row;

    class bar_row_scoreboard;
        int                  range_lo;
        int                  range_hi;
        logic [1:0]          comp_sel;
        bit [COUNT_BITS-1:0] counts [NUM_BUCKETS];
        bit [COUNT_BITS-1:0] peak;
        t_bar_row            rows_due [$];
        int                  errors;

        function new();
            range_lo = 0;
            range_hi = 65536;
            comp_sel = COMP_X;
            peak     = '0;
            errors   = 0;
            foreach (counts[b]) counts[b] = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_RANGE_LOW:  range_lo = data;
                CFG_RANGE_HIGH: range_hi = data;
                CFG_COMP_SEL:   comp_sel = data[1:0];
                default: ;
            endcase
        endfunction

        function int bucket_of(int v);
            longint span;
            longint q;
            span = longint'(range_hi) - longint'(range_lo);
            if (span <= 0) return 0;
            q = ((longint'(v) - longint'(range_lo)) * (NUM_BUCKETS - 1)) / span;
            if (q < 0) return 0;
            if (q > NUM_BUCKETS - 1) return NUM_BUCKETS - 1;
            return int'(q);
        endfunction

        function void note_sample(int x, int y, int z, int w, bit fin);
            int                 v;
            int                 b;
            longint unsigned    thr;
            t_bar_row           row;
            case (comp_sel)
                COMP_X:  v = x;
                COMP_Y:  v = y;
                COMP_Z:  v = z;
                default: v = w;
            endcase
            b = bucket_of(v);
            if (counts[b] != '1) counts[b]++;
            if (!fin) return;
            peak = '0;
            foreach (counts[i]) if (counts[i] > peak) peak = counts[i];
            for (int r = ROWS - 1; r >= 0; r--) begin
                thr = (longint'(r) * longint'(peak)) / ROWS;
                row.index = ROW_IDX_W'(r);
                row.bits  = '0;
                row.last  = (r == 0);
                foreach (counts[i]) if (counts[i] > thr) row.bits[i] = 1'b1;
                rows_due.push_back(row);
            end
            foreach (counts[i]) counts[i] = '0;
        endfunction

        function void check_row(logic [ROW_IDX_W-1:0] idx, logic [ROW_BITS_W-1:0] bits,
                                logic last);
            t_bar_row want;
            if (rows_due.size() == 0) begin
                $error("unexpected row transaction: row_index %0d row_bits %h", idx, bits);
                errors++;
                return;
            end
            want = rows_due.pop_front();
            if (idx !== want.index) begin
                $error("row_index: expected %0d, actual %0d", want.index, idx);
                errors++;
            end
            if (bits !== want.bits) begin
                $error("row_bits: expected %h, actual %h", want.bits, bits);
                errors++;
            end
            if (last !== want.last) begin
                $error("row_last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic signed [VAL_W-1:0] i_comp_x;
    logic signed [VAL_W-1:0] i_comp_y;
    logic signed [VAL_W-1:0] i_comp_z;
    logic signed [VAL_W-1:0] i_comp_w;
    logic                  i_final_sample;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [ROW_IDX_W-1:0]  o_row_index;
    logic [ROW_BITS_W-1:0] o_row_bits;
    logic                  o_row_last;

    bar_row_scoreboard board;
    bit                steady = 1'b0;
    int                random_sent;

    histogram_bar_rows dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_comp_x       (i_comp_x),
        .i_comp_y       (i_comp_y),
        .i_comp_z       (i_comp_z),
        .i_comp_w       (i_comp_w),
        .i_final_sample (i_final_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_row_index    (o_row_index),
        .o_row_bits     (o_row_bits),
        .o_row_last     (o_row_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // row transactions are checked against the oldest predicted row
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_row(o_row_index, o_row_bits, o_row_last);
    end

    initial begin
        int burst_left;
        int quiet_left;
        burst_left  = 0;
        quiet_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady) begin
                i_out_stall <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (quiet_left > 0) begin
                quiet_left--;
                i_out_stall <= 1'b0;
            end else if ($urandom_range(7) == 0) begin
                quiet_left  = $urandom_range(20, 80);
                i_out_stall <= 1'b0;
            end else if ($urandom_range(4) == 0) begin
                burst_left  = $urandom_range(0, 9);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // entered and left at a falling edge; valid stays high until accepted
    task automatic send_sample(logic [1:0] comp, int val, bit fin);
        int c [4];
        foreach (c[i]) c[i] = $urandom;
        c[comp] = val;
        if (!steady && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_comp_x       <= c[0];
        i_comp_y       <= c[1];
        i_comp_z       <= c[2];
        i_comp_w       <= c[3];
        i_final_sample <= fin;
        do @(posedge i_clk); while (o_in_stall);
        board.note_sample(c[0], c[1], c[2], c[3], fin);
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (board.rows_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        board.set_register(idx, data);
    endtask

    task automatic write_setup(int lo, int hi, logic [1:0] sel);
        write_reg(CFG_RANGE_LOW, lo);
        write_reg(CFG_RANGE_HIGH, hi);
        write_reg(CFG_COMP_SEL, CFG_W'(sel));
    endtask

    function automatic int value_in_range(int lo, int hi);
        longint          span;
        longint unsigned r;
        span = longint'(hi) - longint'(lo);
        if (span <= 0 || $urandom_range(7) == 0) return $urandom;
        r = {$urandom, $urandom};
        return int'(longint'(lo) + longint'(r % unsigned'(span)));
    endfunction

    task automatic random_setup();
        int     lo;
        int     hi;
        longint top;
        case ($urandom_range(9))
            0: begin
                lo = 32'sh80000000;
                hi = 32'sh7fffffff;
            end
            1: begin
                lo = $urandom;
                hi = lo;
            end
            2: begin
                hi = $urandom_range(0, 32'h3fffffff);
                lo = hi + $urandom_range(1, 32'h00100000);
            end
            default: begin
                lo  = $signed($urandom) >>> $urandom_range(0, 12);
                top = longint'(lo) + longint'($urandom_range(1, 32'd1 << $urandom_range(0, 31)));
                if (top > 64'sh7fffffff) top = 64'sh7fffffff;
                hi  = int'(top);
            end
        endcase
        write_setup(lo, hi, 2'($urandom_range(3)));
    endtask

    initial begin
        int         frame_len;
        bit         hot;
        int         spots [3];
        logic [1:0] sel;
        int         val;

        board          = new();
        i_rst_n        = 1'b0;
        i_cfg_wen      = 1'b0;
        i_cfg_index    = '0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_comp_x       = '0;
        i_comp_y       = '0;
        i_comp_z       = '0;
        i_comp_w       = '0;
        i_final_sample = 1'b0;
        random_sent    = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset range 0..1.0 on x, values beyond both ends clamp
        send_sample(COMP_X, 32'sh80000000, 1'b0);
        send_sample(COMP_X, 32'sh7fffffff, 1'b0);
        send_sample(COMP_X, 0, 1'b0);
        send_sample(COMP_X, 65535, 1'b0);
        send_sample(COMP_X, 32768, 1'b0);
        send_sample(COMP_X, -1, 1'b0);
        send_sample(COMP_X, 65536, 1'b1);

        // full signed range on w
        settle_block();
        write_setup(32'sh80000000, 32'sh7fffffff, COMP_W);
        send_sample(COMP_W, 32'sh80000000, 1'b0);
        send_sample(COMP_W, 32'sh7fffffff, 1'b0);
        send_sample(COMP_W, 0, 1'b0);
        send_sample(COMP_W, -1, 1'b0);
        send_sample(COMP_W, 32'sh40000000, 1'b1);

        // empty range on y
        settle_block();
        write_setup(100, 100, COMP_Y);
        send_sample(COMP_Y, 32'sh7fffffff, 1'b0);
        send_sample(COMP_Y, 32'sh80000000, 1'b0);
        send_sample(COMP_Y, 5, 1'b1);

        // inverted range on z
        settle_block();
        write_setup(5 << 16, -(5 << 16), COMP_Z);
        send_sample(COMP_Z, 0, 1'b0);
        send_sample(COMP_Z, 32'sh12345678, 1'b1);

        // single-sample frame, then a frame with one dominant bucket
        settle_block();
        write_setup(-65536, 196608, COMP_X);
        send_sample(COMP_X, 65536, 1'b1);
        repeat (5) send_sample(COMP_X, 0, 1'b0);
        send_sample(COMP_X, -65536, 1'b0);
        send_sample(COMP_X, 196608, 1'b1);

        while (random_sent < RANDOM_ITEMS) begin
            settle_block();
            random_setup();
            sel       = board.comp_sel;
            frame_len = $urandom_range(1, 16);
            hot       = ($urandom_range(1) == 1);
            foreach (spots[i]) spots[i] = value_in_range(board.range_lo, board.range_hi);
            for (int i = 0; i < frame_len; i++) begin
                if (hot)
                    val = spots[$urandom_range(2)];
                else
                    val = value_in_range(board.range_lo, board.range_hi);
                send_sample(sel, val, i == frame_len - 1);
                random_sent++;
                if (random_sent >= RANDOM_ITEMS - STEADY_ITEMS) steady = 1'b1;
            end
        end

        settle_block();
        if (board.errors == 0 && board.rows_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
